FILE: hw/rtl/ctwa_pkg.sv
// Package for the coordinate table with aging: table size, mode and status codes,
// the record layout and the record memory port structs.
// No dependencies.
package ctwa_pkg;

  localparam int TABLE_ENTRIES = 32;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
  localparam int COUNT_FIELD_W = 6;

  localparam logic [31:0] PERIOD_RESET = 32'd3000;

  typedef enum logic [2:0] {
    MODE_ADD    = 3'd0,
    MODE_REMOVE = 3'd1,
    MODE_LOOKUP = 3'd2,
    MODE_SWEEP  = 3'd3,
    MODE_CLEAR  = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_UPDATED   = 3'd1,
    ST_STALE     = 3'd2,
    ST_REMOVED   = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_FOUND     = 3'd5,
    ST_FULL      = 3'd6,
    ST_DONE      = 3'd7
  } status_t;

  // One table record as held in the record memory.
  typedef struct packed {
    logic        [15:0] id;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] seq;
    logic        [31:0] stamp;
    logic signed [16:0] last_hop;
    logic signed [8:0]  hops;
  } rec_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    rec_t             data;
  } ram_wr_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
  } ram_rd_t;

endpackage

FILE: hw/rtl/ctwa_ram.sv
// Record memory of the coordinate table: one write port, one read port,
// registered read data. Depends on ctwa_pkg.
module ctwa_ram import ctwa_pkg::*; (
  input  logic    clk,
  input  ram_wr_t wr,
  input  ram_rd_t rd,
  output rec_t    rdata
);

  rec_t mem [TABLE_ENTRIES];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      rdata <= mem[rd.addr];
    end
  end

endmodule

FILE: hw/rtl/coordinate_table_with_aging.sv
// Coordinate table with aging: keyed node records in a one-port-read memory.
// A new item is taken only in IDLE, once the previous operation has finished; the slot scan
// reads the record memory one slot per cycle for every operation.
// Reset (rst, synchronous): all slots invalid, count zero, period 3000 ms.
// Depends on ctwa_pkg and ctwa_ram.
module coordinate_table_with_aging import ctwa_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  // configuration write (useful period)
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [31:0]              cfg_data,
  // item channel
  input  logic                     item_valid,
  output logic                     item_stall,
  input  logic [2:0]               mode,
  input  logic [15:0]              node_id,
  input  logic signed [31:0]       pos_x,
  input  logic signed [31:0]       pos_y,
  input  logic signed [31:0]       seq_no,
  input  logic [31:0]              stamp,
  input  logic signed [16:0]       last_hop,
  input  logic signed [8:0]        hop_count,
  input  logic [31:0]              now,
  // result channel
  output logic                     result_valid,
  input  logic                     result_stall,
  output logic [2:0]               status,
  output logic signed [31:0]       found_x,
  output logic signed [31:0]       found_y,
  output logic signed [31:0]       found_seq,
  output logic [31:0]              found_stamp,
  output logic signed [16:0]       found_last_hop,
  output logic signed [8:0]        found_hops,
  output logic [COUNT_FIELD_W-1:0] entry_count,
  output logic [COUNT_FIELD_W-1:0] aged_count
);

  // Sequencer: IDLE takes a transaction, SCAN walks every slot through the
  // record memory, FINISH commits the table change and loads the result register.
  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  state_t state;

  logic [31:0] period;

  // valid bits live in flops so reset and clear-all act at once
  logic [TABLE_ENTRIES-1:0] slot_valid;
  logic [CNT_W-1:0]         cnt;

  // latched operation
  logic [2:0]  op_mode;
  rec_t        op_rec;
  logic [31:0] op_now;

  // scan pipeline: read issue side and check side, the check side following in the next cycle
  logic             rd_active;
  logic [IDX_W-1:0] rd_idx;
  logic             chk_en;
  logic [IDX_W-1:0] chk_idx;

  // scan findings
  logic             hit;
  logic [IDX_W-1:0] hit_idx;
  rec_t             hit_rec;
  logic             free_hit;
  logic [IDX_W-1:0] free_idx;
  logic [CNT_W-1:0] aged;

  ram_wr_t ram_wr;
  ram_rd_t ram_rd;
  rec_t    rdata;

  logic item_accept;
  logic fin_go;

  // per-slot check of the record just read
  logic        chk_valid;
  logic        chk_match;
  logic [31:0] chk_age;
  logic        chk_old;

  // finish decisions
  logic             wr_want;
  logic             set_en;
  logic             clr_en;
  logic             clr_all;
  logic [IDX_W-1:0] upd_idx;
  logic [CNT_W-1:0] cnt_next;
  status_t          res_status;
  rec_t             res_rec;
  logic [CNT_W-1:0] res_aged;

  assign cfg_ready   = 1'b1;
  assign item_stall  = (state != S_IDLE);
  assign item_accept = item_valid && !item_stall;
  // the result register must be free, or freed in this cycle, before committing
  assign fin_go      = (state == S_FINISH) && (!result_valid || !result_stall);

  assign ram_rd.en   = rd_active;
  assign ram_rd.addr = rd_idx;

  ctwa_ram u_ram (
    .clk   (clk),
    .wr    (ram_wr),
    .rd    (ram_rd),
    .rdata (rdata)
  );

  always_comb begin
    chk_valid = slot_valid[chk_idx];
    chk_match = chk_valid && (rdata.id == op_rec.id);
    chk_age   = op_now - rdata.stamp;        // modulo 2^32
    chk_old   = chk_valid && (chk_age > period);
  end

  // Commit logic for the end of an operation. Writes happen only in FINISH and
  // the next scan starts no earlier than the following cycle, so a record write
  // is always visible to the next read of that slot without forwarding.
  always_comb begin
    wr_want    = 1'b0;
    set_en     = 1'b0;
    clr_en     = 1'b0;
    clr_all    = 1'b0;
    upd_idx    = hit_idx;
    cnt_next   = cnt;
    res_status = ST_DONE;
    res_rec    = '0;
    res_aged   = '0;
    case (op_mode)
      MODE_ADD: begin
        if (hit) begin
          if (op_rec.seq > hit_rec.seq) begin
            wr_want    = 1'b1;
            res_status = ST_UPDATED;
          end else begin
            res_status = ST_STALE;
          end
        end else if (free_hit) begin
          wr_want    = 1'b1;
          set_en     = 1'b1;
          upd_idx    = free_idx;
          cnt_next   = cnt + CNT_W'(1);
          res_status = ST_INSERTED;
        end else begin
          res_status = ST_FULL;
        end
      end
      MODE_REMOVE: begin
        if (hit) begin
          clr_en     = 1'b1;
          cnt_next   = cnt - CNT_W'(1);
          res_status = ST_REMOVED;
        end else begin
          res_status = ST_NOT_FOUND;
        end
      end
      MODE_LOOKUP: begin
        if (hit) begin
          res_rec    = hit_rec;
          res_status = ST_FOUND;
        end else begin
          res_status = ST_NOT_FOUND;
        end
      end
      MODE_SWEEP: begin
        res_aged = aged;
      end
      MODE_CLEAR: begin
        clr_all  = 1'b1;
        res_aged = cnt;
        cnt_next = '0;
      end
      default: begin
        res_status = ST_DONE;
      end
    endcase
    ram_wr.en   = wr_want && fin_go;
    ram_wr.addr = upd_idx;
    ram_wr.data = op_rec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      period <= PERIOD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      period <= cfg_data;
    end
  end

  // control state and valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      slot_valid   <= '0;
      cnt          <= '0;
      rd_active    <= 1'b0;
      rd_idx       <= '0;
      chk_en       <= 1'b0;
      chk_idx      <= '0;
      hit          <= 1'b0;
      free_hit     <= 1'b0;
      aged         <= '0;
      result_valid <= 1'b0;
    end else begin
      chk_en  <= rd_active;
      chk_idx <= rd_idx;
      if (rd_active) begin
        rd_idx <= rd_idx + IDX_W'(1);
        if (rd_idx == IDX_W'(TABLE_ENTRIES - 1)) begin
          rd_active <= 1'b0;
        end
      end

      if (chk_en) begin
        if (chk_match && !hit) begin
          hit     <= 1'b1;
          hit_idx <= chk_idx;
        end
        if (!chk_valid && !free_hit) begin
          free_hit <= 1'b1;
          free_idx <= chk_idx;
        end
        if ((op_mode == MODE_SWEEP) && chk_old) begin
          slot_valid[chk_idx] <= 1'b0;
          cnt                 <= cnt - CNT_W'(1);
          aged                <= aged + CNT_W'(1);
        end
      end

      if (fin_go) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (item_accept) begin
            state     <= S_SCAN;
            rd_active <= 1'b1;
            rd_idx    <= '0;
            hit       <= 1'b0;
            free_hit  <= 1'b0;
            aged      <= '0;
          end
        end
        S_SCAN: begin
          if (chk_en && (chk_idx == IDX_W'(TABLE_ENTRIES - 1))) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (fin_go) begin
            state <= S_IDLE;
            cnt   <= cnt_next;
            if (clr_all) begin
              slot_valid <= '0;
            end else if (set_en) begin
              slot_valid[upd_idx] <= 1'b1;
            end else if (clr_en) begin
              slot_valid[upd_idx] <= 1'b0;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (item_accept) begin
      op_mode         <= mode;
      op_now          <= now;
      op_rec.id       <= node_id;
      op_rec.x        <= pos_x;
      op_rec.y        <= pos_y;
      op_rec.seq      <= seq_no;
      op_rec.stamp    <= stamp;
      op_rec.last_hop <= last_hop;
      op_rec.hops     <= hop_count;
    end
    if (chk_en && chk_match && !hit) begin
      hit_rec <= rdata;
    end
    if (fin_go) begin
      status         <= res_status;
      found_x        <= res_rec.x;
      found_y        <= res_rec.y;
      found_seq      <= res_rec.seq;
      found_stamp    <= res_rec.stamp;
      found_last_hop <= res_rec.last_hop;
      found_hops     <= res_rec.hops;
      entry_count    <= COUNT_FIELD_W'(cnt_next);
      aged_count     <= COUNT_FIELD_W'(res_aged);
    end
  end

`ifndef ASSERT_OFF
  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    cnt == CNT_W'($countones(slot_valid)))
    else $error("entry count out of step with valid bits");

  a_accept_starts_scan: assert property (@(posedge clk) disable iff (rst)
    item_accept |=> (state == S_SCAN) && rd_active && (rd_idx == '0))
    else $error("accepted transaction did not start a scan");

  a_write_only_at_finish: assert property (@(posedge clk) disable iff (rst)
    ram_wr.en |-> (state == S_FINISH) && !rd_active && !chk_en)
    else $error("record write outside finish");

  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state == S_FINISH))
    else $error("result raised without a finished operation");
`endif

endmodule
